// ===== rtl/core/point_to_segment_offset_3d_macros.svh =====
// Assertion macros shared by the segment offset RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef POINT_TO_SEGMENT_OFFSET_3D_MACROS_SVH
`define POINT_TO_SEGMENT_OFFSET_3D_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define PTSO_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Antecedent implies consequent in the following cycle.
`define PTSO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== rtl/core/ptso_pkg.sv =====
// Shared types and constants for the point to segment offset block.
// No dependencies.
package ptso_pkg;

   typedef enum logic [1:0] {
      REGION_DEGEN    = 2'd0,
      REGION_BEFORE   = 2'd1,
      REGION_PAST     = 2'd2,
      REGION_INTERIOR = 2'd3
   } region_type;

   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_X   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_Y   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_END_Z   = 3'd5;

endpackage

// ===== rtl/core/ptso_div_stage.sv =====
// One restoring division step with its pipeline register.
// Standalone; instantiated in a chain by point_to_segment_offset_3d.
module ptso_div_stage #(
   parameter int LW   = 66,
   parameter int QW   = 17,
   parameter int SIDW = 299
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [LW-1:0]   in_rem,
   input  logic [QW-1:0]   in_quo,
   input  logic [LW-1:0]   in_l2,
   input  logic [SIDW-1:0] in_side,
   output logic            out_valid,
   output logic [LW-1:0]   out_rem,
   output logic [QW-1:0]   out_quo,
   output logic [LW-1:0]   out_l2,
   output logic [SIDW-1:0] out_side
);

   logic            valid_ff;
   logic [LW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [LW-1:0]   l2_ff;
   logic [SIDW-1:0] side_ff;
   logic [LW:0]     shifted, diff;
   logic            take;

   // The remainder stays below the divisor, so the difference fits LW bits.
   always_comb begin
      shifted = {in_rem, 1'b0};
      take    = (shifted >= {1'b0, in_l2});
      diff    = shifted - {1'b0, in_l2};
      rem_in  = take ? diff[LW-1:0] : shifted[LW-1:0];
      quo_in  = {in_quo[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         l2_ff   <= in_l2;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_l2    = l2_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/core/point_to_segment_offset_3d.sv =====
// Offset from a query point to the nearest point on a configured 3D segment.
// Throughput: one point per cycle while the output is not stalled; the divider is
// one restoring step per stage.
// A stalled result stalls the whole pipeline in place; nothing is dropped.
// Synchronous active-high reset clears the segment registers and all valid bits.
`include "point_to_segment_offset_3d_macros.svh"

module point_to_segment_offset_3d
   import ptso_pkg::*;
#(
   parameter int COORD_BITS  = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // point_x, point_y, point_z, then zero fill
   input  logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // offset_x, offset_y, offset_z, then zero fill
   output logic [((3*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // region
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [COORD_BITS-1:0]         csr_wdata
);

   localparam int TDW  = ((3*COORD_BITS+7)/8)*8;
   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2*DW;
   localparam int LW   = PW;
   localparam int DTW  = PW + 2;
   localparam int QW   = T_FRAC_BITS + 1;
   localparam int MW   = QW + 1 + DW;
   localparam int SW   = MW + 2;
   localparam int SIDW = 9*DW + 2;

   localparam logic signed [MW:0] RND_HALF = (MW+1)'(1) <<< (T_FRAC_BITS-1);
   localparam logic signed [SW-1:0] SAT_MAX =
      {{(SW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN =
      {{(SW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
   localparam logic [QW-1:0] T_ONE = QW'(1) << T_FRAC_BITS;

   // Segment endpoints.
   logic signed [COORD_BITS-1:0] v_ff [3];
   logic signed [COORD_BITS-1:0] w_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= '0;
            w_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_X: v_ff[0] <= csr_wdata;
            CSR_START_Y: v_ff[1] <= csr_wdata;
            CSR_START_Z: v_ff[2] <= csr_wdata;
            CSR_END_X:   w_ff[0] <= csr_wdata;
            CSR_END_Y:   w_ff[1] <= csr_wdata;
            CSR_END_Z:   w_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Global advance: every stage moves when the output slot is free or drained.
   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: differences.
   logic                 v1_ff;
   logic signed [DW-1:0] pv1_ff [3], pv1_in [3];
   logic signed [DW-1:0] d1_ff  [3], d1_in  [3];
   logic signed [DW-1:0] vp1_ff [3], vp1_in [3];
   logic signed [DW-1:0] wp1_ff [3], wp1_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pv1_in[i] = DW'($signed(req_tdata[i*COORD_BITS +: COORD_BITS])) - DW'(v_ff[i]);
         d1_in[i]  = DW'(w_ff[i]) - DW'(v_ff[i]);
         vp1_in[i] = DW'(v_ff[i]) - DW'($signed(req_tdata[i*COORD_BITS +: COORD_BITS]));
         wp1_in[i] = DW'(w_ff[i]) - DW'($signed(req_tdata[i*COORD_BITS +: COORD_BITS]));
      end
   end

   // Stage 2: products.
   logic                 v2_ff;
   logic signed [PW-1:0] sq2_ff [3], sq2_in [3];
   logic signed [PW-1:0] pr2_ff [3], pr2_in [3];
   logic signed [DW-1:0] d2_ff [3], vp2_ff [3], wp2_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq2_in[i] = d1_ff[i] * d1_ff[i];
         pr2_in[i] = pv1_ff[i] * d1_ff[i];
      end
   end

   // Stage 3: squared length and dot product.
   logic                  v3_ff;
   logic [LW-1:0]         l2_3_ff, l2_3_in;
   logic signed [DTW-1:0] dot3_ff, dot3_in;
   logic signed [DW-1:0]  d3_ff [3], vp3_ff [3], wp3_ff [3];

   always_comb begin
      l2_3_in  = LW'($unsigned(sq2_ff[0])) + LW'($unsigned(sq2_ff[1]))
               + LW'($unsigned(sq2_ff[2]));
      dot3_in  = DTW'(pr2_ff[0]) + DTW'(pr2_ff[1]) + DTW'(pr2_ff[2]);
   end

   // Stage 4: region decision and first quotient bit (the integer bit of t).
   logic                  v4_ff;
   logic [LW-1:0]         rem4_ff, rem4_in, l2_4_ff;
   logic [QW-1:0]         quo4_ff, quo4_in;
   logic [SIDW-1:0]       side4_ff, side4_in;
   region_type            region4_in;
   logic [LW:0]           dot_mag, l2_ext, dot_diff;
   logic                  dot_ge;

   always_comb begin
      dot_mag  = dot3_ff[DTW-2:0];
      l2_ext   = {1'b0, l2_3_ff};
      dot_ge   = (dot_mag >= l2_ext);
      dot_diff = dot_mag - l2_ext;
      if (l2_3_ff == '0) begin
         region4_in = REGION_DEGEN;
      end else if (dot3_ff[DTW-1]) begin
         region4_in = REGION_BEFORE;
      end else if (dot_mag > l2_ext) begin
         region4_in = REGION_PAST;
      end else begin
         region4_in = REGION_INTERIOR;
      end
      rem4_in  = dot_ge ? dot_diff[LW-1:0] : dot_mag[LW-1:0];
      quo4_in  = {{(QW-1){1'b0}}, dot_ge};
      side4_in = {region4_in, d3_ff[2], d3_ff[1], d3_ff[0],
                  vp3_ff[2], vp3_ff[1], vp3_ff[0], wp3_ff[2], wp3_ff[1], wp3_ff[0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pv1_ff[i] <= pv1_in[i];
            d1_ff[i]  <= d1_in[i];
            vp1_ff[i] <= vp1_in[i];
            wp1_ff[i] <= wp1_in[i];
            sq2_ff[i] <= sq2_in[i];
            pr2_ff[i] <= pr2_in[i];
            d2_ff[i]  <= d1_ff[i];
            vp2_ff[i] <= vp1_ff[i];
            wp2_ff[i] <= wp1_ff[i];
            d3_ff[i]  <= d2_ff[i];
            vp3_ff[i] <= vp2_ff[i];
            wp3_ff[i] <= wp2_ff[i];
         end
         l2_3_ff  <= l2_3_in;
         dot3_ff  <= dot3_in;
         rem4_ff  <= rem4_in;
         quo4_ff  <= quo4_in;
         l2_4_ff  <= l2_3_ff;
         side4_ff <= side4_in;
      end
   end

   // Divider chain: one fraction bit of t per stage.
   logic            dv_valid [T_FRAC_BITS+1];
   logic [LW-1:0]   dv_rem   [T_FRAC_BITS+1];
   logic [QW-1:0]   dv_quo   [T_FRAC_BITS+1];
   logic [LW-1:0]   dv_l2    [T_FRAC_BITS+1];
   logic [SIDW-1:0] dv_side  [T_FRAC_BITS+1];

   assign dv_valid[0] = v4_ff;
   assign dv_rem[0]   = rem4_ff;
   assign dv_quo[0]   = quo4_ff;
   assign dv_l2[0]    = l2_4_ff;
   assign dv_side[0]  = side4_ff;

   for (genvar k = 0; k < T_FRAC_BITS; k++) begin : g_div
      ptso_div_stage #(
         .LW   (LW),
         .QW   (QW),
         .SIDW (SIDW)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv_valid[k]),
         .in_rem    (dv_rem[k]),
         .in_quo    (dv_quo[k]),
         .in_l2     (dv_l2[k]),
         .in_side   (dv_side[k]),
         .out_valid (dv_valid[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_quo   (dv_quo[k+1]),
         .out_l2    (dv_l2[k+1]),
         .out_side  (dv_side[k+1])
      );
   end

   // Unpack the side band leaving the divider.
   region_type           dv_region;
   logic signed [DW-1:0] dv_d [3], dv_vp [3], dv_wp [3];
   logic [QW-1:0]        t_q;

   always_comb begin
      t_q       = dv_quo[T_FRAC_BITS];
      dv_region = region_type'(dv_side[T_FRAC_BITS][SIDW-1 -: 2]);
      for (int i = 0; i < 3; i++) begin
         dv_wp[i] = dv_side[T_FRAC_BITS][i*DW +: DW];
         dv_vp[i] = dv_side[T_FRAC_BITS][(3+i)*DW +: DW];
         dv_d[i]  = dv_side[T_FRAC_BITS][(6+i)*DW +: DW];
      end
   end

   // Stage M: t times the direction.
   logic                 vm_ff;
   logic signed [MW-1:0] prod_ff [3], prod_in [3];
   logic signed [DW-1:0] vpm_ff [3], wpm_ff [3];
   region_type           regm_ff;

   // Stage R: round to nearest, ties upward, back to coordinate scale.
   logic                 vr_ff;
   logic signed [MW:0]   rq_ff [3], rq_in [3], rsum [3];
   logic signed [DW-1:0] vpr_ff [3], wpr_ff [3];
   region_type           regr_ff;

   // Output stage: base selection and saturation.
   logic [COORD_BITS-1:0] off_ff [3], off_in [3];
   region_type            region_ff;
   logic signed [SW-1:0]  base [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = $signed({1'b0, t_q}) * dv_d[i];
         rsum[i]    = (MW+1)'(prod_ff[i]) + RND_HALF;
         rq_in[i]   = rsum[i] >>> T_FRAC_BITS;
         case (regr_ff)
            REGION_INTERIOR: base[i] = SW'(vpr_ff[i]) + SW'(rq_ff[i]);
            REGION_PAST:     base[i] = SW'(wpr_ff[i]);
            default:         base[i] = SW'(vpr_ff[i]);
         endcase
         if (base[i] > SAT_MAX) begin
            off_in[i] = SAT_MAX[COORD_BITS-1:0];
         end else if (base[i] < SAT_MIN) begin
            off_in[i] = SAT_MIN[COORD_BITS-1:0];
         end else begin
            off_in[i] = base[i][COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff        <= 1'b0;
         vr_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vm_ff        <= dv_valid[T_FRAC_BITS];
         vr_ff        <= vm_ff;
         rsp_valid_ff <= vr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
            vpm_ff[i]  <= dv_vp[i];
            wpm_ff[i]  <= dv_wp[i];
            rq_ff[i]   <= rq_in[i];
            vpr_ff[i]  <= vpm_ff[i];
            wpr_ff[i]  <= wpm_ff[i];
            off_ff[i]  <= off_in[i];
         end
         regm_ff   <= dv_region;
         regr_ff   <= regm_ff;
         region_ff <= regr_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = region_ff;
   assign rsp_tdata  = TDW'({off_ff[2], off_ff[1], off_ff[0]});

   `PTSO_ASSERT_SAME(a_stall_blocks_input, clock, reset,
      rsp_valid_ff && !rsp_tready, !req_tready)
   `PTSO_ASSERT_NEXT(a_accept_enters_pipe, clock, reset,
      req_tvalid && req_tready, v1_ff)
   `PTSO_ASSERT_SAME(a_interior_t_bounded, clock, reset,
      dv_valid[T_FRAC_BITS] && (dv_region == REGION_INTERIOR), t_q <= T_ONE)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for point_to_segment_offset_3d.
// Depends on ptso_pkg and the RTL only; predicts each offset and region and
// compares every result transfer against the oldest prediction.
`timescale 1ns / 100ps

module tb_top;
   import ptso_pkg::*;

   localparam int CB = 32;
   localparam int TF = 16;
   localparam int LATENCY = TF + 7;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES = 10;
   localparam int RANDOM_PER_PHASE = 160;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
   localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

   typedef struct packed {
      logic [CB-1:0] z;
      logic [CB-1:0] y;
      logic [CB-1:0] x;
   } point_t;

   typedef struct {
      logic [CB-1:0] ox, oy, oz;
      region_type region;
   } offset_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [95:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;

   // Segment registers as the block should hold them: start v, end w.
   logic signed [CB-1:0] seg_start [3];
   logic signed [CB-1:0] seg_end [3];

   point_t pending_points [$];
   offset_t expected_offsets [$];
   bit req_taken = 0;
   bit no_idle = 0;
   int errors = 0;
   int results_checked = 0;
   int stall_cycles = 0;
   int region_seen [4];

   point_to_segment_offset_3d u_top (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [CB-1:0] clamp_coord(logic signed [127:0] val);
      if (val > 128'(CMAX)) return CMAX;
      if (val < 128'(CMIN)) return CMIN;
      return val[CB-1:0];
   endfunction

   function automatic offset_t nearest_offset(point_t pt);
      logic signed [127:0] v [3], w [3], p [3], d [3], res [3];
      logic signed [127:0] len_sq, dot, t, prod;
      offset_t o;
      p[0] = $signed(pt.x);
      p[1] = $signed(pt.y);
      p[2] = $signed(pt.z);
      len_sq = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = seg_start[i];
         w[i] = seg_end[i];
         d[i] = w[i] - v[i];
         len_sq += d[i] * d[i];
         dot += (p[i] - v[i]) * d[i];
      end
      if (len_sq == 0) begin
         o.region = REGION_DEGEN;
         for (int i = 0; i < 3; i++) res[i] = v[i] - p[i];
      end else if (dot < 0) begin
         o.region = REGION_BEFORE;
         for (int i = 0; i < 3; i++) res[i] = v[i] - p[i];
      end else if (dot > len_sq) begin
         o.region = REGION_PAST;
         for (int i = 0; i < 3; i++) res[i] = w[i] - p[i];
      end else begin
         o.region = REGION_INTERIOR;
         t = (dot <<< TF) / len_sq;
         // Round half toward plus infinity, then drop the fraction bits of the product.
         for (int i = 0; i < 3; i++) begin
            prod = t * d[i] + (128'sd1 <<< (TF - 1));
            res[i] = v[i] - p[i] + (prod >>> TF);
         end
      end
      o.ox = clamp_coord(res[0]);
      o.oy = clamp_coord(res[1]);
      o.oz = clamp_coord(res[2]);
      return o;
   endfunction

   // Driver: a new point goes out once the previous one has transferred.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            req_taken = 0;
            if (pending_points.size() > 0 && (no_idle || $urandom_range(99) >= 15)) begin
               req_tdata <= pending_points.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= no_idle || $urandom_range(99) >= 15;
      end
   end

   // Monitor, predictor and watchdog.
   always @(posedge clock) begin
      offset_t exp_o;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_offsets.push_back(nearest_offset(req_tdata));
            req_taken = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            if (expected_offsets.size() == 0) begin
               $display("%0t: unexpected result offset=%h region=%0d",
                        $time, rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               exp_o = expected_offsets.pop_front();
               region_seen[exp_o.region]++;
               if (rsp_tdata[31:0] !== exp_o.ox) begin
                  $display("%0t: offset_x expected %h actual %h", $time, exp_o.ox,
                           rsp_tdata[31:0]);
                  errors++;
               end
               if (rsp_tdata[63:32] !== exp_o.oy) begin
                  $display("%0t: offset_y expected %h actual %h", $time, exp_o.oy,
                           rsp_tdata[63:32]);
                  errors++;
               end
               if (rsp_tdata[95:64] !== exp_o.oz) begin
                  $display("%0t: offset_z expected %h actual %h", $time, exp_o.oz,
                           rsp_tdata[95:64]);
                  errors++;
               end
               if (rsp_tuser !== exp_o.region) begin
                  $display("%0t: region expected %0d actual %0d", $time, exp_o.region,
                           rsp_tuser);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CB-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_START_X) seg_start[0] = val;
      else if (idx == CSR_START_Y) seg_start[1] = val;
      else if (idx == CSR_START_Z) seg_start[2] = val;
      else if (idx == CSR_END_X) seg_end[0] = val;
      else if (idx == CSR_END_Y) seg_end[1] = val;
      else if (idx == CSR_END_Z) seg_end[2] = val;
   endtask

   task automatic load_segment(logic [CB-1:0] v [3], logic [CB-1:0] w [3]);
      write_reg(CSR_START_X, v[0]);
      write_reg(CSR_START_Y, v[1]);
      write_reg(CSR_START_Z, v[2]);
      write_reg(CSR_END_X, w[0]);
      write_reg(CSR_END_Y, w[1]);
      write_reg(CSR_END_Z, w[2]);
      // Spare indexes must leave the segment alone.
      write_reg(CSR_SPARE_LO, $urandom);
      write_reg(CSR_SPARE_HI, $urandom);
   endtask

   // A point somewhere along the line through the segment, a little off it,
   // so that all three regions come up often.
   function automatic point_t point_near_segment();
      logic signed [63:0] frac, base;
      logic [CB-1:0] c [3];
      frac = $signed(64'($urandom_range(131072))) - 64'sd32768;
      for (int i = 0; i < 3; i++) begin
         base = 64'(seg_start[i]) +
                (((64'(seg_end[i]) - 64'(seg_start[i])) * frac) >>> TF);
         c[i] = base[CB-1:0] + CB'($signed($urandom_range(8191)) - 4096);
      end
      return '{z: c[2], y: c[1], x: c[0]};
   endfunction

   task automatic wait_drained();
      while (pending_points.size() > 0 || req_tvalid || expected_offsets.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   initial begin
      logic [CB-1:0] v [3], w [3];
      logic [CB-1:0] extremes [4];
      point_t pt;
      extremes = '{CMIN, CMAX, '0, 32'h0001_0000};
      seg_start = '{default: '0};
      seg_end = '{default: '0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         no_idle = (ph == 5);
         case (ph)
            0: ; // registers still hold their reset values: a degenerate segment
            1: begin
               v = '{CMIN, CMIN, CMIN};
               w = '{CMAX, CMAX, CMAX};
               load_segment(v, w);
            end
            2: begin
               v = '{CMAX, CMIN, CMAX};
               w = '{CMIN, CMAX, CMIN};
               load_segment(v, w);
            end
            3: begin
               for (int i = 0; i < 3; i++) v[i] = $urandom;
               load_segment(v, v);
            end
            4: begin
               v = '{32'h0001_0000, '0, '0};
               w = '{32'h0005_0000, '0, '0};
               load_segment(v, w);
            end
            default: begin
               for (int i = 0; i < 3; i++) begin
                  v[i] = $urandom;
                  w[i] = (ph % 2) ? $urandom
                                  : v[i] + CB'($signed($urandom_range(1 << 22)) - (1 << 21));
               end
               load_segment(v, w);
            end
         endcase

         // Directed points: field extremes, the endpoints and the midpoint.
         if (ph < 5) begin
            for (int a = 0; a < 4; a++)
               pending_points.push_back('{z: extremes[(a + 2) % 4], y: extremes[(a + 1) % 4],
                                          x: extremes[a]});
            pending_points.push_back('{z: seg_start[2], y: seg_start[1], x: seg_start[0]});
            pending_points.push_back('{z: seg_end[2], y: seg_end[1], x: seg_end[0]});
            for (int i = 0; i < 3; i++)
               pt[i*CB +: CB] = CB'((64'(seg_start[i]) + 64'(seg_end[i])) >>> 1);
            pending_points.push_back(pt);
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if ($urandom_range(99) < 65)
               pending_points.push_back(point_near_segment());
            else
               pending_points.push_back({$urandom, $urandom, $urandom});
         end
         wait_drained();
      end

      if (expected_offsets.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  expected_offsets.size());
         errors++;
      end
      $display("Checked %0d results over %0d segment settings; regions degenerate/before/",
               results_checked, NUM_PHASES);
      $display("past/interior seen %0d/%0d/%0d/%0d, %0d errors.", region_seen[0],
               region_seen[1], region_seen[2], region_seen[3], errors);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ptso_pkg.sv
rtl/core/ptso_div_stage.sv
rtl/core/point_to_segment_offset_3d.sv
tb/tb_top.sv
